FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files.
// Clocked checks are compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop on every rising edge of clk, skipped while rst_n is low.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop on every rising edge of clk, reset included.
`define ASSERT_ALW(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALW(label, clk, prop, msg)
`endif
`endif

FILE: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and microcode for the linear probe hash table
// Request and response payloads, control word, status and the control store.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

    localparam int KEY_W     = 31;
    localparam int ENTRY_W   = KEY_W + 1;
    localparam int SLOT_W    = 4;
    localparam int KEY_BYTES = 4;
    localparam int UPC_W     = 3;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    // jump types
    localparam logic [1:0] JT_GOTO     = 2'd0;
    localparam logic [1:0] JT_LOOP     = 2'd1;
    localparam logic [1:0] JT_DISPATCH = 2'd2;
    localparam logic [1:0] JT_HOLD     = 2'd3;

    // microcode addresses
    localparam logic [UPC_W-1:0] S_WAIT = 3'd0;
    localparam logic [UPC_W-1:0] S_INIT = 3'd1;
    localparam logic [UPC_W-1:0] S_CLR  = 3'd2;
    localparam logic [UPC_W-1:0] S_MOD  = 3'd3;
    localparam logic [UPC_W-1:0] S_RD   = 3'd4;
    localparam logic [UPC_W-1:0] S_CHK  = 3'd5;
    localparam logic [UPC_W-1:0] S_DONE = 3'd6;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              found;
        logic              table_full;
    } rsp_t;

    typedef struct packed {
        logic             accept_en;
        logic             clr_wr;
        logic             mod_step;
        logic             rd_home;
        logic             probe;
        logic             emit;
        logic             lim_tab;
        logic [1:0]       jt;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic loop_exit;
        logic out_busy;
    } stat_t;

    function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] upc);
        ctrl_t cw;
        cw = '0;
        unique case (upc)
            S_WAIT:
            begin
                cw.accept_en = 1'b1;
                cw.jt        = JT_DISPATCH;
                cw.target    = S_WAIT;
            end
            S_INIT:
            begin
                cw.clr_wr  = 1'b1;
                cw.lim_tab = 1'b1;
                cw.jt      = JT_LOOP;
                cw.target  = S_WAIT;
            end
            S_CLR:
            begin
                cw.clr_wr  = 1'b1;
                cw.lim_tab = 1'b1;
                cw.jt      = JT_LOOP;
                cw.target  = S_DONE;
            end
            S_MOD:
            begin
                cw.mod_step = 1'b1;
                cw.jt       = JT_LOOP;
                cw.target   = S_RD;
            end
            S_RD:
            begin
                cw.rd_home = 1'b1;
                cw.jt      = JT_GOTO;
                cw.target  = S_CHK;
            end
            S_CHK:
            begin
                cw.probe   = 1'b1;
                cw.lim_tab = 1'b1;
                cw.jt      = JT_LOOP;
                cw.target  = S_DONE;
            end
            S_DONE:
            begin
                cw.emit   = 1'b1;
                cw.jt     = JT_HOLD;
                cw.target = S_WAIT;
            end
            default:
            begin
                cw.jt     = JT_GOTO;
                cw.target = S_WAIT;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 13
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/lpht_useq.sv
// ----------------------------------------------------------------------------
// lpht_useq: microcode sequencer
// Holds the micro program counter, reads the control store, resolves jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_useq
    import lpht_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [1:0] opcode,
    input  wire stat_t      stat,
    output ctrl_t           ctrl
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [UPC_W-1:0] disp_target;

    assign ctrl = ucode_rom(upc_reg);

    always_comb
    begin
        case (opcode) inside
            OP_CLEAR:             disp_target = S_CLR;
            OP_INSERT, OP_SEARCH: disp_target = S_MOD;
            default:              disp_target = S_DONE;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.jt)
            JT_GOTO:     upc_next = ctrl.target;
            JT_LOOP:     upc_next = stat.loop_exit ? ctrl.target : upc_reg;
            JT_DISPATCH: upc_next = accept ? disp_target : upc_reg;
            JT_HOLD:     upc_next = stat.out_busy ? upc_reg : ctrl.target;
            default:     upc_next = S_WAIT;
        endcase
    end

    // start with the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_INIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lpht_dpath.sv
// ----------------------------------------------------------------------------
// lpht_dpath: hash table datapath
// Key registers, home slot reduction, loop counter, probe compare, response.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_dpath
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 13
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire ctrl_t                         ctrl,
    input  wire logic                          accept,
    input  wire req_t                          req,
    input  wire logic                          rsp_stall,
    output stat_t                              stat,
    output logic                               rsp_valid,
    output rsp_t                               rsp,
    output logic                               ram_wr_en,
    output logic [$clog2(TABLE_SIZE)-1:0]      ram_wr_addr,
    output logic [ENTRY_W-1:0]                 ram_wr_data,
    output logic [$clog2(TABLE_SIZE)-1:0]      ram_rd_addr,
    input  wire logic [ENTRY_W-1:0]            ram_rd_data
);

    localparam int IW  = $clog2(TABLE_SIZE);
    localparam int CW  = (IW > 2) ? IW : 2;
    localparam int SHW = KEY_BYTES * 8;

    // reduce r*256 + b modulo TABLE_SIZE, one bit per step
    function automatic logic [IW-1:0] mod_byte(input logic [IW-1:0] r_in,
                                               input logic [7:0]    b);
        logic [IW:0]   t;
        logic [IW-1:0] r;
        r = r_in;
        for (int i = 7; i >= 0; i--)
        begin
            t = {r, b[i]};
            if (t >= (IW+1)'(TABLE_SIZE))
            begin
                t = t - (IW+1)'(TABLE_SIZE);
            end
            r = t[IW-1:0];
        end
        return r;
    endfunction

    logic [1:0]       op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [SHW-1:0]   sh_reg;
    logic [IW-1:0]    rem_reg;
    logic [IW-1:0]    addr_reg;
    logic [IW-1:0]    addr_next;
    logic [CW-1:0]    cnt_reg;
    logic [IW-1:0]    res_slot_reg;
    logic             res_found_reg;
    logic             res_full_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic cnt_last;
    logic hit;
    logic rd_used;
    logic is_insert;
    logic load_rsp;

    assign is_insert = (op_reg == OP_INSERT);
    assign rd_used   = ram_rd_data[KEY_W];
    assign hit       = is_insert ? !rd_used
                                 : (rd_used && (ram_rd_data[KEY_W-1:0] == key_reg));
    assign cnt_last  = ctrl.lim_tab ? (cnt_reg == CW'(TABLE_SIZE - 1))
                                    : (cnt_reg == CW'(KEY_BYTES - 1));
    assign addr_next = (addr_reg == IW'(TABLE_SIZE - 1)) ? '0 : addr_reg + 1'b1;

    assign stat.loop_exit = cnt_last || (ctrl.probe && hit);
    assign stat.out_busy  = rsp_valid_reg && rsp_stall;
    assign load_rsp       = ctrl.emit && !stat.out_busy;

    // read home slot first, then run one slot ahead of the compare
    assign ram_rd_addr = ctrl.rd_home ? rem_reg : addr_next;
    assign ram_wr_en   = ctrl.clr_wr || (ctrl.probe && is_insert && hit);
    assign ram_wr_addr = ctrl.clr_wr ? cnt_reg[IW-1:0] : addr_reg;
    assign ram_wr_data = {!ctrl.clr_wr, key_reg};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg        <= req.opcode;
            key_reg       <= req.key;
            sh_reg        <= SHW'(req.key);
            rem_reg       <= '0;
            res_slot_reg  <= '0;
            res_found_reg <= 1'b0;
            res_full_reg  <= 1'b0;
        end
        if (ctrl.mod_step)
        begin
            rem_reg <= mod_byte(rem_reg, sh_reg[SHW-1 -: 8]);
            sh_reg  <= sh_reg << 8;
        end
        if (ctrl.rd_home)
        begin
            addr_reg <= rem_reg;
        end
        if (ctrl.probe)
        begin
            addr_reg <= addr_next;
            if (hit)
            begin
                res_slot_reg  <= addr_reg;
                res_found_reg <= 1'b1;
            end
            else if (cnt_last)
            begin
                res_full_reg <= is_insert;
            end
        end
        if (load_rsp)
        begin
            rsp_reg.slot       <= SLOT_W'(res_slot_reg);
            rsp_reg.found      <= res_found_reg;
            rsp_reg.table_full <= res_full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clr_wr || ctrl.mod_step || ctrl.probe)
            begin
                // drop back to zero on loop exit
                cnt_reg <= stat.loop_exit ? '0 : cnt_reg + 1'b1;
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing hash table with linear probing
// Clear, insert and search requests run under a microcoded sequencer.
//
//   channel | signals                        | payload
//   --------+--------------------------------+--------------------------------
//   request | req_valid, req_stall, req_data | opcode, key
//   response| rsp_valid, rsp_stall, rsp_data | slot, found, table_full
//
// Insert and search probe k slots, k = 1 .. TABLE_SIZE, after a home slot
// reduction that takes one step per key byte; each probe is one RAM read.
// Clear writes one slot per cycle; opcode 3 goes straight to the response.
// After reset a clearing pass over all TABLE_SIZE slots runs before the
// first request is taken. A stalled response holds in the output
// register; the next request is taken meanwhile and waits at its last step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = 13
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp_data
);

    localparam int IW = $clog2(TABLE_SIZE);

    ctrl_t              ctrl;
    stat_t              stat;
    logic               accept;
    logic               ram_wr_en;
    logic [IW-1:0]      ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic [IW-1:0]      ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    assign req_stall = !ctrl.accept_en;
    assign accept    = req_valid && ctrl.accept_en;

    lpht_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .opcode (req_data.opcode),
        .stat   (stat),
        .ctrl   (ctrl)
    );

    lpht_dpath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .accept      (accept),
        .req         (req_data),
        .rsp_stall   (rsp_stall),
        .stat        (stat),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    `ASSERT_RST(a_one_in_flight, clk, rst_n, accept |=> !accept, "request taken while busy")
    `ASSERT_RST(a_found_not_full, clk, rst_n, rsp_valid && rsp_data.found |-> !rsp_data.table_full, "found and full together")
    `ASSERT_RST(a_miss_slot_zero, clk, rst_n, rsp_valid && !rsp_data.found |-> rsp_data.slot == '0, "miss with nonzero slot")

endmodule

`default_nettype wire
